### rtl/ics_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ics_pkg
// Shared command codes, status codes and the divider response type.
// ----------------------------------------------------------------------------
package ics_pkg;

	localparam logic [1:0] CMD_COEF  = 2'd0;
	localparam logic [1:0] CMD_RHS   = 2'd1;
	localparam logic [1:0] CMD_SOLVE = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_SINGULAR = 2'd1;
	localparam logic [1:0] STAT_NONINT   = 2'd2;

	typedef struct packed {
		logic        done;
		logic        exact;
		logic [63:0] quot;
	} div_rsp_t;

endpackage

### rtl/ics_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ics_mul
// 64-bit wrapping multiplier built on one 32x32 multiplier, accumulating the partial products in turn.
// ----------------------------------------------------------------------------
module ics_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] op_a,
	input  logic [63:0] op_b,
	output logic        done,
	output logic [63:0] prod
);

	logic [1:0]  phase_q;
	logic        done_q;
	logic [63:0] a_q, b_q, p_q;
	logic [31:0] ma, mb;
	logic [63:0] mp;

	always_comb begin
		case (phase_q)
			2'd1: begin ma = a_q[31:0];  mb = b_q[31:0];  end
			2'd2: begin ma = a_q[31:0];  mb = b_q[63:32]; end
			default: begin ma = a_q[63:32]; mb = b_q[31:0]; end
		endcase
	end

	assign mp = 64'(ma) * 64'(mb);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 2'd0;
			done_q  <= 1'b0;
		end else begin
			done_q <= (phase_q == 2'd3);
			if (start) phase_q <= 2'd1;
			else if (phase_q != 2'd0) phase_q <= (phase_q == 2'd3) ? 2'd0 : phase_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= op_a;
			b_q <= op_b;
		end
		if (phase_q == 2'd1) p_q <= mp;
		else if (phase_q != 2'd0) p_q <= p_q + {mp[31:0], 32'd0};
	end

	assign done = done_q;
	assign prod = p_q;

endmodule

### rtl/ics_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ics_div
// Signed 64-bit restoring divider, one quotient bit per cycle, with an
// exactness flag.
// ----------------------------------------------------------------------------
module ics_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [63:0]     num,
	input  logic [63:0]     den,
	output ics_pkg::div_rsp_t rsp
);

	logic        busy_q, done_q, neg_q;
	logic [6:0]  cnt_q;
	logic [63:0] rem_q, quo_q, md_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, md_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[63] ^ den[63];
			quo_q <= num[63] ? 64'd0 - num : num;
			md_q  <= den[63] ? 64'd0 - den : den;
			rem_q <= 64'd0;
		end else if (busy_q) begin
			if (!trial[64]) rem_q <= trial[63:0];
			else rem_q <= {rem_q[62:0], quo_q[63]};
			quo_q <= {quo_q[62:0], ~trial[64]};
		end
	end

	assign rsp.done  = done_q;
	assign rsp.exact = (rem_q == 64'd0) && (md_q != 64'd0);
	assign rsp.quot  = neg_q ? 64'd0 - quo_q : quo_q;

endmodule

### rtl/integer_cramer_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_cramer_solver
// Integer linear system solver by Cramer's rule with 64-bit wrapping
// determinants.
// ----------------------------------------------------------------------------
// A load transaction (cmd 0 or 1) is accepted while the solver is idle. A solve
// walks every n-digit tuple of column indices in base n and, for each
// permutation, runs n products through the 64-bit multiplier; a solve takes
// up to n+1 determinants plus a divide per unknown, then emits the results
// one by one. The request side stalls for the whole solve; results wait in
// an output register.
module integer_cramer_solver #(
	parameter int MAX_N     = 4,
	parameter int ELEM_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  matrix_size,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  cmd,
	input  logic [1:0]  row_index,
	input  logic [1:0]  col_index,
	input  logic signed [31:0] element_value,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [1:0]  status,
	output logic [1:0]  unknown_index,
	output logic signed [63:0] solution_value,
	output logic        last
);

	localparam int DW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
	localparam int NW = $clog2(MAX_N + 1);
	localparam int SW = (ELEM_BITS < 32) ? ELEM_BITS : 32;
	localparam bit SIGN_EXT = (ELEM_BITS <= 32);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PERM  = 4'd1;
	localparam logic [3:0] ST_MULGO = 4'd2;
	localparam logic [3:0] ST_MULW  = 4'd3;
	localparam logic [3:0] ST_ADD   = 4'd4;
	localparam logic [3:0] ST_NEXT  = 4'd5;
	localparam logic [3:0] ST_DDONE = 4'd6;
	localparam logic [3:0] ST_DIVGO = 4'd7;
	localparam logic [3:0] ST_DIVW  = 4'd8;
	localparam logic [3:0] ST_EMIT  = 4'd9;

	logic [3:0]  state_q;
	logic [2:0]  msize_q;
	logic [NW-1:0] n_q, k_q;
	logic [MAX_N-1:0][DW-1:0] dig_q, dig_inc;
	logic [SW-1:0] coef_q [MAX_N][MAX_N];
	logic [SW-1:0] rhs_q [MAX_N];
	logic [63:0] quot_q [MAX_N];
	logic [63:0] acc_q, det_q, main_det_q;
	logic        col_pass_q, emit_err_q;
	logic [1:0]  err_stat_q;
	logic [DW-1:0] col_q, err_col_q, emit_idx_q;
	logic        rsp_valid_q, rsp_last_q;
	logic [1:0]  rsp_status_q, rsp_idx_q;
	logic [63:0] rsp_value_q;

	logic        is_perm, is_odd, is_last, carry;
	logic [DW-1:0] erow, ecol;
	logic [SW-1:0] eraw;
	logic [63:0] elem;
	logic        mul_start, mul_done;
	logic [63:0] mul_p;
	logic        div_start;
	ics_pkg::div_rsp_t div_rsp;
	logic        req_acc, rsp_load;
	logic [NW-1:0] n_clamp;

	assign req_acc  = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_load = !rsp_valid_q || !rsp_stall;

	always_comb begin
		if (msize_q == 3'd0) n_clamp = NW'(1);
		else if (32'(msize_q) > MAX_N) n_clamp = NW'(MAX_N);
		else n_clamp = NW'(msize_q);
	end

	always_comb begin
		is_perm = 1'b1;
		is_odd  = 1'b0;
		is_last = 1'b1;
		for (int i = 0; i < MAX_N; i++) begin
			if (i < 32'(n_q)) begin
				if (NW'(dig_q[i]) != n_q - NW'(1)) is_last = 1'b0;
				for (int j = i + 1; j < MAX_N; j++) begin
					if (j < 32'(n_q)) begin
						if (dig_q[i] == dig_q[j]) is_perm = 1'b0;
						if (dig_q[i] > dig_q[j]) is_odd = ~is_odd;
					end
				end
			end
		end
	end

	always_comb begin
		carry = 1'b1;
		dig_inc = dig_q;
		for (int i = 0; i < MAX_N; i++) begin
			if (carry) begin
				if (NW'(dig_q[i]) == n_q - NW'(1)) dig_inc[i] = '0;
				else begin
					dig_inc[i] = dig_q[i] + DW'(1);
					carry = 1'b0;
				end
			end
		end
	end

	assign erow = k_q[DW-1:0];
	assign ecol = dig_q[erow];
	assign eraw = (col_pass_q && ecol == col_q) ? rhs_q[erow] : coef_q[erow][ecol];
	assign elem = SIGN_EXT ? {{(64-SW){eraw[SW-1]}}, eraw} : {{(64-SW){1'b0}}, eraw};

	assign mul_start = (state_q == ST_MULGO);
	assign div_start = (state_q == ST_DIVGO);

	ics_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.op_a   (acc_q),
		.op_b   (elem),
		.done   (mul_done),
		.prod   (mul_p)
	);

	ics_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (det_q),
		.den    (main_det_q),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk) begin
		if (req_acc && cmd == ics_pkg::CMD_COEF && 32'(row_index) < MAX_N
				&& 32'(col_index) < MAX_N) begin
			coef_q[DW'(row_index)][DW'(col_index)] <= element_value[SW-1:0];
		end
		if (req_acc && cmd == ics_pkg::CMD_RHS && 32'(row_index) < MAX_N) begin
			rhs_q[DW'(row_index)] <= element_value[SW-1:0];
		end
		if (state_q == ST_DIVW && div_rsp.done && div_rsp.exact) begin
			quot_q[col_q] <= div_rsp.quot;
		end
		if (state_q == ST_EMIT && rsp_load) begin
			rsp_status_q <= emit_err_q ? err_stat_q : ics_pkg::STAT_OK;
			rsp_idx_q    <= emit_err_q ? 2'(err_col_q) : 2'(emit_idx_q);
			rsp_value_q  <= emit_err_q ? 64'd0 : quot_q[emit_idx_q];
			rsp_last_q   <= emit_err_q || (NW'(emit_idx_q) == n_q - NW'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			msize_q     <= 3'd1;
			main_det_q  <= 64'd0;
			n_q         <= NW'(1);
			k_q         <= '0;
			dig_q       <= '0;
			acc_q       <= 64'd0;
			det_q       <= 64'd0;
			col_pass_q  <= 1'b0;
			col_q       <= '0;
			emit_err_q  <= 1'b0;
			err_stat_q  <= ics_pkg::STAT_OK;
			err_col_q   <= '0;
			emit_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) msize_q <= matrix_size;
			if (state_q == ST_EMIT && rsp_load) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc && cmd == ics_pkg::CMD_SOLVE) begin
						n_q        <= n_clamp;
						dig_q      <= '0;
						det_q      <= 64'd0;
						col_pass_q <= 1'b0;
						col_q      <= '0;
						state_q    <= ST_PERM;
					end
				end
				ST_PERM: begin
					acc_q   <= 64'd1;
					k_q     <= '0;
					state_q <= is_perm ? ST_MULGO : ST_NEXT;
				end
				ST_MULGO: state_q <= ST_MULW;
				ST_MULW: begin
					if (mul_done) begin
						acc_q <= mul_p;
						k_q   <= k_q + NW'(1);
						state_q <= (k_q + NW'(1) == n_q) ? ST_ADD : ST_MULGO;
					end
				end
				ST_ADD: begin
					det_q   <= is_odd ? det_q - acc_q : det_q + acc_q;
					state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					if (is_last) state_q <= ST_DDONE;
					else begin
						dig_q   <= dig_inc;
						state_q <= ST_PERM;
					end
				end
				ST_DDONE: begin
					if (!col_pass_q) begin
						main_det_q <= det_q;
						if (det_q == 64'd0) begin
							emit_err_q <= 1'b1;
							err_stat_q <= ics_pkg::STAT_SINGULAR;
							err_col_q  <= '0;
							state_q    <= ST_EMIT;
						end else begin
							col_pass_q <= 1'b1;
							col_q      <= '0;
							dig_q      <= '0;
							det_q      <= 64'd0;
							state_q    <= ST_PERM;
						end
					end else begin
						state_q <= ST_DIVGO;
					end
				end
				ST_DIVGO: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_rsp.done) begin
						if (!div_rsp.exact) begin
							emit_err_q <= 1'b1;
							err_stat_q <= ics_pkg::STAT_NONINT;
							err_col_q  <= col_q;
							state_q    <= ST_EMIT;
						end else if (NW'(col_q) == n_q - NW'(1)) begin
							emit_err_q <= 1'b0;
							emit_idx_q <= '0;
							state_q    <= ST_EMIT;
						end else begin
							col_q   <= col_q + DW'(1);
							dig_q   <= '0;
							det_q   <= 64'd0;
							state_q <= ST_PERM;
						end
					end
				end
				ST_EMIT: begin
					if (rsp_load) begin
						if (emit_err_q || NW'(emit_idx_q) == n_q - NW'(1)) state_q <= ST_IDLE;
						else emit_idx_q <= emit_idx_q + DW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = rsp_status_q;
	assign unknown_index  = rsp_idx_q;
	assign solution_value = rsp_value_q;
	assign last           = rsp_last_q;

`ifndef SYNTHESIS
	a_mul_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> state_q == ST_MULW)
		else $error("multiplier finished outside its wait state");
	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && !emit_err_q) |-> NW'(emit_idx_q) < n_q)
		else $error("result index beyond system size");
	a_err_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status != ics_pkg::STAT_OK) |-> (last && solution_value == 64'd0))
		else $error("failure result not final or nonzero");
	a_no_main_det_zero_pass: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVGO) |-> main_det_q != 64'd0)
		else $error("division started with zero determinant");
`endif

endmodule
